[rtl/lc3b_pkg.sv]
package lc3b_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } cmd_t;

  localparam logic [3:0] OPC_BR   = 4'h0;
  localparam logic [3:0] OPC_ADD  = 4'h1;
  localparam logic [3:0] OPC_LDB  = 4'h2;
  localparam logic [3:0] OPC_STB  = 4'h3;
  localparam logic [3:0] OPC_JSR  = 4'h4;
  localparam logic [3:0] OPC_AND  = 4'h5;
  localparam logic [3:0] OPC_LDW  = 4'h6;
  localparam logic [3:0] OPC_STW  = 4'h7;
  localparam logic [3:0] OPC_XOR  = 4'h9;
  localparam logic [3:0] OPC_JMP  = 4'hC;
  localparam logic [3:0] OPC_SHF  = 4'hD;
  localparam logic [3:0] OPC_LEA  = 4'hE;
  localparam logic [3:0] OPC_TRAP = 4'hF;

  localparam logic [15:0] START_PC_RST = 16'h3000;

  // micro-program step addresses
  typedef enum logic [2:0] {
    UA_IDLE  = 3'd0,
    UA_FETCH = 3'd1,
    UA_EXEC  = 3'd2,
    UA_MEM   = 3'd3,
    UA_DONE  = 3'd4,
    UA_CLEAR = 3'd5
  } uaddr_t;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_DISP = 2'd1,
    SEQ_HOLD = 2'd2,
    SEQ_WAIT = 2'd3
  } seq_t;

  // memory address source
  typedef enum logic [1:0] {
    MA_IN = 2'd0,
    MA_PC = 2'd1,
    MA_EA = 2'd2
  } masel_t;

  typedef struct packed {
    masel_t mar_sel;
    logic   mem_rd;
    logic   ld_ir;
    logic   exec;
    logic   mem_wb;
    logic   out_ld;
    logic   clr;
    seq_t   seq;
    uaddr_t jmp;
  } uword_t;

  function automatic uword_t ucode(input uaddr_t a);
    uword_t w;
    w = '0;
    unique case (a)
      UA_IDLE:  begin w.seq = SEQ_DISP; w.jmp = UA_IDLE; end
      UA_FETCH: begin w.mar_sel = MA_PC; w.mem_rd = 1'b1; w.seq = SEQ_NEXT; end
      UA_EXEC:  begin w.ld_ir = 1'b1; w.exec = 1'b1; w.seq = SEQ_NEXT; end
      UA_MEM:   begin w.mar_sel = MA_EA; w.mem_wb = 1'b1; w.seq = SEQ_NEXT; end
      UA_DONE:  begin w.out_ld = 1'b1; w.seq = SEQ_WAIT; w.jmp = UA_IDLE; end
      UA_CLEAR: begin w.clr = 1'b1; w.seq = SEQ_HOLD; w.jmp = UA_IDLE; end
      default:  begin w.seq = SEQ_HOLD; w.jmp = UA_IDLE; end
    endcase
    return w;
  endfunction

  function automatic logic [15:0] sext(input logic [15:0] v, input int unsigned bits);
    logic [15:0] r;
    r = v;
    for (int i = 0; i < 16; i++) begin
      if (i >= bits) r[i] = v[bits - 1];
    end
    return r;
  endfunction

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] c;
    if (v[15]) c = 3'b100;
    else if (v == 16'h0000) c = 3'b010;
    else c = 3'b001;
    return c;
  endfunction

endpackage

[rtl/lc3b_instruction_step.sv]
// a read or write passes the micro-steps mem and done; a step passes fetch, exec, mem
// and done; each transaction waits in done while out_stall holds the output, and a new
// one is accepted only once the sequencer is back in idle; a step reads its instruction
// in fetch and its data in exec, and loads or stores in mem
// after reset a clearing pass zeroes memory, one word per cycle, before in_stall
// falls; pc resets to 16'h3000, flags to z, registers to zero
module lc3b_instruction_step
  import lc3b_pkg::*;
#(
  parameter int MEM_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_address,
  input  logic [15:0] in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pc,
  output logic        out_flag_n,
  output logic        out_flag_z,
  output logic        out_flag_p,
  output logic        out_reg_written,
  output logic [2:0]  out_reg_index,
  output logic [15:0] out_reg_value,
  output logic        out_mem_written,
  output logic [15:0] out_read_word,
  output logic        out_halted
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rdata_r;
  logic [AW-1:0] clr_r;

  logic [15:0] pc_r, regs_r [8];
  logic [2:0]  cc_r;
  logic [15:0] ea_r, wdat_r, addr_r, data_r;
  logic [1:0]  op_r;
  logic        st_r, stb_r, ld_r, ldb_r, trap_r, halt_r;
  logic [2:0]  dr_r;
  logic        wr_r, mw_r;
  logic [2:0]  widx_r;
  logic [15:0] wval_r, rword_r;

  uword_t uw;
  logic   idle, start, clear_done, out_free;

  assign start      = in_valid && !in_stall;
  assign in_stall   = !idle;
  assign clear_done = (clr_r == AW'(MEM_WORDS - 1));
  assign out_free   = !out_valid || !out_stall;

  uaddr_t start_ua;
  always_comb begin
    start_ua = UA_MEM;
    if (cmd_t'(in_op) == OP_STEP) start_ua = UA_FETCH;
  end

  lc3b_useq u_seq (
    .clk, .rst_n, .start, .start_ua, .clear_done, .out_free, .uw, .idle
  );

  // memory address; while idle the port reads the incoming address
  logic [15:0] ma;
  always_comb begin
    unique case (uw.mar_sel)
      MA_PC:   ma = pc_r;
      MA_EA:   ma = (op_r == OP_STEP) ? ea_r : addr_r;
      default: ma = idle ? in_address : addr_r;
    endcase
  end
  logic [AW-1:0] widx_m;
  assign widx_m = ma[AW:1];

  // memory write in the data step
  logic        mem_we;
  logic [15:0] mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wd = wdat_r;
    if (uw.mem_wb) begin
      if (op_r == OP_WRITE) begin
        mem_we = 1'b1; mem_wd = data_r;
      end else if (op_r == OP_STEP && st_r) begin
        mem_we = 1'b1;
        if (stb_r) begin
          mem_wd = ea_r[0] ? {wdat_r[7:0], rdata_r[7:0]} : {rdata_r[15:8], wdat_r[7:0]};
        end
      end
    end
  end

  // read-modify-write for stb uses rdata_r from the exec step's prefetch
  logic [AW-1:0] ea_nxt_w;
  logic [AW-1:0] ra;
  assign ra = uw.exec ? ea_nxt_w : widx_m;

  always_ff @(posedge clk) begin
    if (uw.clr) mem[clr_r] <= 16'h0000;
    else if (mem_we) mem[widx_m] <= mem_wd;
    rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (uw.clr) clr_r <= clr_r + AW'(1);
  end

  // execute
  logic [15:0] ir, base, src2, off6, off9, off11, pcinc, v, ea, npc, sr;
  logic [3:0]  amt;
  logic        wr, st, stb, ld, ldb, trap;
  logic [2:0]  widx, ncc;
  always_comb begin
    ir    = rdata_r;
    pcinc = pc_r + 16'd2;
    base  = regs_r[ir[8:6]];
    sr    = regs_r[ir[11:9]];
    off6  = sext(ir, 6);
    off9  = sext(ir, 9);
    off11 = sext(ir, 11);
    src2  = ir[5] ? sext(ir, 5) : regs_r[ir[2:0]];
    amt   = ir[3:0];
    wr = 1'b0; st = 1'b0; stb = 1'b0; ld = 1'b0; ldb = 1'b0; trap = 1'b0;
    widx = ir[11:9]; v = 16'h0000; ea = 16'h0000; npc = pcinc; ncc = cc_r;
    case (ir[15:12])
      OPC_BR:  if ((ir[11:9] & cc_r) != 3'b000) npc = pcinc + {off9[14:0], 1'b0};
      OPC_ADD: begin v = base + src2; wr = 1'b1; ncc = cc_of(v); end
      OPC_AND: begin v = base & src2; wr = 1'b1; ncc = cc_of(v); end
      OPC_XOR: begin v = base ^ src2; wr = 1'b1; ncc = cc_of(v); end
      OPC_LDB: begin ea = base + off6; ld = 1'b1; ldb = 1'b1; wr = 1'b1; end
      OPC_STB: begin ea = base + off6; st = 1'b1; stb = 1'b1; end
      OPC_LDW: begin ea = base + {off6[14:0], 1'b0}; ld = 1'b1; wr = 1'b1; end
      OPC_STW: begin ea = base + {off6[14:0], 1'b0}; st = 1'b1; end
      OPC_JSR: begin
        wr = 1'b1; widx = 3'd7; v = pcinc;
        npc = ir[11] ? pcinc + {off11[14:0], 1'b0} : base;
      end
      OPC_JMP: npc = base;
      OPC_SHF: begin
        if (!ir[4]) v = base << amt;
        else if (!ir[5] || !base[15]) v = base >> amt;
        else v = ~((~base) >> amt);
        wr = 1'b1; ncc = cc_of(v);
      end
      OPC_LEA: begin v = pcinc + {off9[14:0], 1'b0}; wr = 1'b1; end
      OPC_TRAP: begin
        ea = {7'd0, ir[7:0], 1'b0}; ld = 1'b1; trap = 1'b1;
        wr = 1'b1; widx = 3'd7; v = pcinc;
      end
      default: ;
    endcase
  end
  assign ea_nxt_w = ea[AW:1];

  logic halt_now;
  assign halt_now = (op_r == OP_STEP) && (pc_r == 16'h0000);

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= in_op; addr_r <= in_address; data_r <= in_data;
      wr_r <= 1'b0; mw_r <= 1'b0; halt_r <= 1'b0; st_r <= 1'b0; ld_r <= 1'b0;
      rword_r <= 16'h0000;
    end
    if (uw.exec) begin
      if (halt_now) begin
        halt_r <= 1'b1;
      end else begin
        ea_r <= ea; wdat_r <= sr; st_r <= st; stb_r <= stb; ld_r <= ld;
        ldb_r <= ldb; trap_r <= trap; dr_r <= ir[11:9];
        wr_r <= wr; widx_r <= widx; wval_r <= v; mw_r <= st;
      end
    end
    if (uw.mem_wb) begin
      if (op_r == OP_READ) rword_r <= rdata_r;
      if (op_r == OP_STEP && ld_r && !trap_r) begin
        wval_r <= ldb_r ? sext({8'd0, ea_r[0] ? rdata_r[15:8] : rdata_r[7:0]}, 8)
                        : rdata_r;
      end
    end
  end

  // architectural state
  logic [15:0] ldv;
  assign ldv = ldb_r ? sext({8'd0, ea_r[0] ? rdata_r[15:8] : rdata_r[7:0]}, 8) : rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= START_PC_RST;
      cc_r <= 3'b010;
      for (int i = 0; i < 8; i++) regs_r[i] <= 16'h0000;
    end else begin
      if (cfg_we) pc_r <= cfg_wdata;
      if (uw.exec && !halt_now && op_r == OP_STEP) begin
        pc_r <= npc;
        cc_r <= ncc;
        if (wr) regs_r[widx] <= v;
      end
      if (uw.mem_wb && op_r == OP_STEP && ld_r) begin
        if (trap_r) pc_r <= rdata_r;
        else begin
          regs_r[dr_r] <= ldv;
          cc_r <= cc_of(ldv);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      if (uw.out_ld && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.out_ld && out_free) begin
      out_pc          <= pc_r;
      out_flag_n      <= cc_r[2];
      out_flag_z      <= cc_r[1];
      out_flag_p      <= cc_r[0];
      out_reg_written <= wr_r;
      out_reg_index   <= wr_r ? widx_r : 3'd0;
      out_reg_value   <= wr_r ? wval_r : 16'h0000;
      out_mem_written <= mw_r;
      out_read_word   <= rword_r;
      out_halted      <= halt_r;
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !idle |-> in_stall) else $error("accept while busy");
  a_no_clr_accept: assert property (@(posedge clk) disable iff (!rst_n)
    uw.clr |-> !start) else $error("accept during clear");
  a_ld_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.out_ld && out_free) |=> out_valid) else $error("result lost");

endmodule

[rtl/lc3b_useq.sv]
module lc3b_useq
  import lc3b_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  uaddr_t start_ua,
  input  logic   clear_done,
  input  logic   out_free,
  output uword_t uw,
  output logic   idle
);

  uaddr_t ua_r, ua_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ua_r <= UA_CLEAR;
    end else begin
      ua_r <= ua_nxt;
    end
  end

  always_comb begin
    uw = ucode(ua_r);
    idle = (ua_r == UA_IDLE);
    ua_nxt = ua_r;
    unique case (uw.seq)
      SEQ_NEXT: ua_nxt = uaddr_t'(ua_r + 3'd1);
      SEQ_DISP: if (start) ua_nxt = start_ua;
      SEQ_HOLD: if (clear_done) ua_nxt = uw.jmp;
      SEQ_WAIT: if (out_free) ua_nxt = uw.jmp;
      default:  ua_nxt = UA_IDLE;
    endcase
  end

endmodule

[bench/lc3b_step_checker.sv]
`timescale 1ns / 100ps
module lc3b_step_checker
  import lc3b_pkg::*;
#(
  parameter int MEM_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_address,
  input  logic [15:0] in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_pc,
  input  logic        out_flag_n,
  input  logic        out_flag_z,
  input  logic        out_flag_p,
  input  logic        out_reg_written,
  input  logic [2:0]  out_reg_index,
  input  logic [15:0] out_reg_value,
  input  logic        out_mem_written,
  input  logic [15:0] out_read_word,
  input  logic        out_halted,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [15:0] pc;
    logic [2:0]  nzp;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] read_word;
    logic        halted;
  } core_state_t;

  logic [15:0] model_pc;
  logic [2:0]  model_nzp;
  logic [15:0] model_regs [8];
  logic [15:0] model_mem [MEM_WORDS];
  core_state_t expected_q [$];

  function automatic int widx(input logic [15:0] a);
    return int'(a >> 1) % MEM_WORDS;
  endfunction

  function automatic logic [15:0] sx(input logic [15:0] v, input int b);
    logic [15:0] r;
    r = v;
    for (int i = b; i < 16; i++) r[i] = v[b - 1];
    return r;
  endfunction

  function automatic logic [2:0] flags_for(input logic [15:0] v);
    if (v[15]) return 3'b100;
    if (v == 16'h0) return 3'b010;
    return 3'b001;
  endfunction

  task automatic execute_item(input logic [1:0] op, input logic [15:0] a,
                              input logic [15:0] d);
    core_state_t r;
    logic [15:0] ir, npc, src2, base, off6, v, ea;
    logic [3:0] opc;
    logic [2:0] dr;
    int wi;
    r = '0;
    if (op == OP_WRITE) model_mem[widx(a)] = d;
    else if (op == OP_READ) r.read_word = model_mem[widx(a)];
    else if (op == OP_STEP) begin
      if (model_pc == 16'h0) r.halted = 1'b1;
      else begin
        ir = model_mem[widx(model_pc)];
        npc = model_pc + 16'd2;
        opc = ir[15:12];
        dr = ir[11:9];
        src2 = ir[5] ? sx(ir, 5) : model_regs[ir[2:0]];
        base = model_regs[ir[8:6]];
        off6 = sx(ir, 6);
        case (opc)
          OPC_BR: if (ir[11:9] & model_nzp) npc = npc + (sx(ir, 9) << 1);
          OPC_ADD, OPC_AND, OPC_XOR: begin
            v = (opc == OPC_ADD) ? base + src2 :
                (opc == OPC_AND) ? (base & src2) : (base ^ src2);
            r.reg_written = 1; r.reg_index = dr; r.reg_value = v;
            model_nzp = flags_for(v);
          end
          OPC_LDB: begin
            ea = base + off6;
            wi = widx(ea);
            v = ea[0] ? {8'h0, model_mem[wi][15:8]} : {8'h0, model_mem[wi][7:0]};
            v = sx(v, 8);
            r.reg_written = 1; r.reg_index = dr; r.reg_value = v;
            model_nzp = flags_for(v);
          end
          OPC_STB: begin
            ea = base + off6;
            wi = widx(ea);
            if (ea[0]) model_mem[wi][15:8] = model_regs[dr][7:0];
            else model_mem[wi][7:0] = model_regs[dr][7:0];
            r.mem_written = 1;
          end
          OPC_JSR: begin
            v = ir[11] ? npc + (sx(ir, 11) << 1) : base;
            r.reg_written = 1; r.reg_index = 3'd7; r.reg_value = npc;
            npc = v;
          end
          OPC_LDW: begin
            v = model_mem[widx(base + (off6 << 1))];
            r.reg_written = 1; r.reg_index = dr; r.reg_value = v;
            model_nzp = flags_for(v);
          end
          OPC_STW: begin
            model_mem[widx(base + (off6 << 1))] = model_regs[dr];
            r.mem_written = 1;
          end
          OPC_JMP: npc = base;
          OPC_SHF: begin
            if (!ir[4]) v = base << ir[3:0];
            else if (!ir[5] || !base[15]) v = base >> ir[3:0];
            else v = ~((~base) >> ir[3:0]);
            r.reg_written = 1; r.reg_index = dr; r.reg_value = v;
            model_nzp = flags_for(v);
          end
          OPC_LEA: begin
            r.reg_written = 1; r.reg_index = dr; r.reg_value = npc + (sx(ir, 9) << 1);
          end
          OPC_TRAP: begin
            v = model_mem[widx({7'h0, ir[7:0], 1'b0})];
            r.reg_written = 1; r.reg_index = 3'd7; r.reg_value = npc;
            npc = v;
          end
          default: ;
        endcase
        if (r.reg_written) model_regs[r.reg_index] = r.reg_value;
        model_pc = npc;
      end
    end
    r.pc = model_pc;
    r.nzp = model_nzp;
    expected_q.push_back(r);
  endtask

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    core_state_t got, exp_r;
    if (!rst_n) begin
      model_pc = START_PC_RST;
      model_nzp = 3'b010;
      for (int i = 0; i < 8; i++) model_regs[i] = 16'h0;
      for (int i = 0; i < MEM_WORDS; i++) model_mem[i] = 16'h0;
      fail_count <= 0;
    end else begin
      if (cfg_we) model_pc = cfg_wdata;
      if (in_valid && !in_stall) execute_item(in_op, in_address, in_data);
      if (out_valid && !out_stall) begin
        got = {out_pc, out_flag_n, out_flag_z, out_flag_p, out_reg_written,
               out_reg_index, out_reg_value, out_mem_written, out_read_word, out_halted};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected pc=%h nzp=%b rw=%b ri=%0d rv=%h mw=%b rd=%h h=%b",
                     $time, exp_r.pc, exp_r.nzp, exp_r.reg_written, exp_r.reg_index,
                     exp_r.reg_value, exp_r.mem_written, exp_r.read_word, exp_r.halted);
            $display("%0t:          actual pc=%h nzp=%b rw=%b ri=%0d rv=%h mw=%b rd=%h h=%b",
                     $time, got.pc, got.nzp, got.reg_written, got.reg_index,
                     got.reg_value, got.mem_written, got.read_word, got.halted);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[bench/lc3b_instruction_step_tb.sv]
`timescale 1ns / 100ps
module lc3b_instruction_step_tb;
  import lc3b_pkg::*;

  localparam int MEM_WORDS = 32768;
  localparam int LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_WRITE;
  logic [15:0] in_address = 16'h0;
  logic [15:0] in_data = 16'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_pc, out_reg_value, out_read_word;
  logic        out_flag_n, out_flag_z, out_flag_p, out_reg_written;
  logic [2:0]  out_reg_index;
  logic        out_mem_written, out_halted;
  int          fail_count, pending_count, cycle_count;
  int          send_idle_pct, stall_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lc3b_instruction_step #(.MEM_WORDS(MEM_WORDS)) uut (.*);
  lc3b_step_checker #(.MEM_WORDS(MEM_WORDS)) checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (cycle_count > LIMIT) begin
      $display("** lc3b_instruction_step: FAILED **");
      $finish;
    end
  end

  // valid stays up after an accept until the next transaction or an idle cycle
  task automatic send(input logic [1:0] op, input logic [15:0] a, input logic [15:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_op <= op; in_address <= a; in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_and_set_pc(input logic [15:0] pc);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= pc;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random instruction word, with the base register often forced to r0 (r1 for some jmp)
  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(3) == 0) w[8:6] = 3'd0;
    if (w[15:12] == OPC_JMP && $urandom_range(1)) w[8:6] = 3'd1;
    return w;
  endfunction

  // one program: a loaded stretch of code, a trap vector, then steps mixed with random transactions and a final read
  task automatic run_program(input logic [15:0] org, input int len);
    for (int i = 0; i < len; i++) send(OP_WRITE, org + 16'(2 * i), rand_instr());
    // one random trap vector aims back at the start of the program
    send(OP_WRITE, 16'($urandom_range(255) * 2), org);
    drain_and_set_pc(org);
    for (int i = 0; i < len + 4; i++) begin
      if ($urandom_range(9) == 0) send(2'($urandom), 16'($urandom), 16'($urandom));
      else send(OP_STEP, 16'($urandom), 16'($urandom));
    end
    send(OP_READ, org + 16'(2 * $urandom_range(len)), 16'h0);
  endtask

  initial begin
    logic [15:0] dir [$];
    int sent, phase;
    send_idle_pct = 0; stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed program at the reset pc
    dir = '{16'h1025, 16'h1A30, 16'h5A7F, 16'h9A3F, 16'hD263, 16'hD273, 16'hD23F,
            16'hD16F, 16'h2A7F, 16'h3A00, 16'h6A40, 16'h7A7F, 16'hE3FF, 16'h0E01,
            16'h0000, 16'h0000, 16'h1A5F, 16'hA000, 16'hB000, 16'h8000, 16'h4801,
            16'h0000, 16'h4040, 16'hF025, 16'hC1C0};
    for (int i = 0; i < dir.size(); i++) send(OP_WRITE, 16'h3000 + 16'(2 * i), dir[i]);
    send(OP_WRITE, 16'h004A, 16'h3000);
    send(OP_WRITE, 16'hFFFF, 16'hFFFF);
    send(OP_READ, 16'hFFFE, 16'h0);
    send(OP_NONE, 16'h1234, 16'hABCD);
    for (int i = 0; i < 28; i++) send(OP_STEP, 16'h0, 16'h0);
    drain_and_set_pc(16'h0000);
    send(OP_STEP, 16'h0, 16'h0);
    drain_and_set_pc(16'hFFFE);
    send(OP_STEP, 16'h0, 16'h0);
    sent = 0;
    while (sent < 1100) begin
      phase = (sent / 90) % 4;
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 56 : 27) : 0;
      stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 56 : 27) : 0;
      run_program(16'($urandom) & 16'hFFFE, 12);
      sent += 30;
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("** lc3b_instruction_step: PASSED **");
    else $display("** lc3b_instruction_step: FAILED **");
    $finish;
  end

endmodule
